### src/soe_pkg.sv
// Shared constants, types and helpers for the spectral onset emphasis unit.
package soe_pkg;

    localparam int NUM_BINS  = 64;
    localparam int IDX_W     = $clog2(NUM_BINS);
    localparam int CNT_W     = $clog2(NUM_BINS + 1);

    localparam int VALUE_W   = 24;
    localparam int SAMPLE_W  = VALUE_W - 1;
    localparam int ENERGY_W  = 29;
    localparam int MULT_W    = 12;
    localparam int TIME_W    = 32;
    localparam int NEED_W    = ENERGY_W + MULT_W;
    localparam int RISE_W    = ENERGY_W + 8;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // x / 100 == (x * ceil(2^30 / 100)) >> 30 for every x below 2^23
    localparam int RECIP_W       = 24;
    localparam int DIV100_SHIFT  = 30;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 24'd10737419;
    localparam int PROD_W        = SAMPLE_W + RECIP_W;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX     = '1;
    localparam logic [MULT_W-1:0]   MULT_RESET     = 12'd256;
    localparam logic [TIME_W-1:0]   INTERVAL_RESET = 32'd100000;

    typedef enum logic [0:0] {
        REG_ENERGY_MULT  = 1'b0,
        REG_MIN_INTERVAL = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } rd_req_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [SAMPLE_W-1:0] data;
    } wr_req_t;

    function automatic logic [ENERGY_W-1:0] energy_sat_add(
        input logic [ENERGY_W-1:0] acc,
        input logic [SAMPLE_W-1:0] v
    );
        logic [ENERGY_W:0] sum;
        sum = {1'b0, acc} + (ENERGY_W + 1)'(v);
        return sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
    endfunction

endpackage

### src/soe_frame_store.sv
// Previous-frame bin store: synchronous RAM, per-entry written flags, write forwarding.
module soe_frame_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  soe_pkg::rd_req_t               rd,
    input  soe_pkg::wr_req_t               wr,
    output logic [soe_pkg::SAMPLE_W-1:0]   rd_data
);

    logic [soe_pkg::SAMPLE_W-1:0] mem [soe_pkg::NUM_BINS];
    logic [soe_pkg::SAMPLE_W-1:0] mem_rdata_reg;
    logic [soe_pkg::NUM_BINS-1:0] written_reg;
    logic [soe_pkg::NUM_BINS-1:0] written_next;
    logic                         entry_valid_reg;
    logic                         fwd_hit_reg;
    logic [soe_pkg::SAMPLE_W-1:0] fwd_data_reg;
    logic                         fwd_hit_next;

    // a write landing on the same edge as the read would be missed by the RAM
    assign fwd_hit_next = wr.en && (wr.idx == rd.idx);

    always_comb
    begin
        written_next = written_reg;
        if (wr.en)
        begin
            written_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd.en)
        begin
            mem_rdata_reg <= mem[rd.idx];
            fwd_data_reg  <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg     <= '0;
            entry_valid_reg <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (rd.en)
            begin
                entry_valid_reg <= written_reg[rd.idx];
                fwd_hit_reg     <= fwd_hit_next;
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = fwd_hit_reg     ? fwd_data_reg  :
                     entry_valid_reg ? mem_rdata_reg : '0;

endmodule

### src/spectral_onset_emphasis_unit.sv
// Spectral onset emphasis unit: bin emphasis, frame energies and color change decision.
// Throughput: one bin request per cycle unless res_ready stalls the output; the frame store is
//   read at accept and written as the bin leaves stage 1, with a bypass when both hit one bin.
// Path: from the accepting edge through emphasis and accumulate, energy multiply and onset
//   compare into the output register.
// Reset: store flags, energies, bin count, last change time and valids clear; config to defaults.
module spectral_onset_emphasis_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [soe_pkg::ADDR_W-1:0]         paddr,
    input  logic [soe_pkg::DATA_W-1:0]         pwdata,
    output logic [soe_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               bin_valid,
    output logic                               bin_ready,
    input  logic signed [soe_pkg::VALUE_W-1:0] bin_value,
    input  logic                               last_bin,
    input  logic [soe_pkg::TIME_W-1:0]         timestamp,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [soe_pkg::VALUE_W-1:0]        emphasized_value,
    output logic                               frame_end,
    output logic                               color_change
);

    // configuration
    logic [soe_pkg::MULT_W-1:0]  energy_multiplier_reg;
    logic [soe_pkg::TIME_W-1:0]  min_interval_reg;
    soe_pkg::reg_idx_t           cfg_idx;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = soe_pkg::reg_idx_t'(paddr[soe_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_multiplier_reg <= soe_pkg::MULT_RESET;
            min_interval_reg      <= soe_pkg::INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                soe_pkg::REG_ENERGY_MULT:
                begin
                    energy_multiplier_reg <= pwdata[soe_pkg::MULT_W-1:0];
                end
                soe_pkg::REG_MIN_INTERVAL:
                begin
                    min_interval_reg <= pwdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            soe_pkg::REG_ENERGY_MULT:  prdata = soe_pkg::DATA_W'(energy_multiplier_reg);
            soe_pkg::REG_MIN_INTERVAL: prdata = min_interval_reg;
            default:                   prdata = '0;
        endcase
    end

    // stage enables
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, res_valid_reg;
    logic en1, en2, en3, en_out, accept;

    assign en_out    = !res_valid_reg || res_ready;
    assign en3       = !p3_valid_reg || en_out;
    assign en2       = !p2_valid_reg || en3;
    assign en1       = !p1_valid_reg || en2;
    assign bin_ready = en1;
    assign accept    = bin_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                p1_valid_reg <= bin_valid;
            end
            if (en2)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (en3)
            begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (en_out)
            begin
                res_valid_reg <= p3_valid_reg;
            end
        end
    end

    // stage 1: clamp, start divide, issue store read
    logic [soe_pkg::CNT_W-1:0]    bin_count_reg, bin_count_next;
    logic [soe_pkg::SAMPLE_W-1:0] sample_clamp;
    logic                         in_range;
    logic [soe_pkg::SAMPLE_W-1:0] p1_sample_reg;
    logic [soe_pkg::PROD_W-1:0]   p1_prod_reg, p1_prod_next;
    logic                         p1_last_reg;
    logic [soe_pkg::TIME_W-1:0]   p1_time_reg;
    logic [soe_pkg::IDX_W-1:0]    p1_idx_reg;
    logic                         p1_in_range_reg;
    soe_pkg::rd_req_t             rd_req;
    soe_pkg::wr_req_t             wr_req;
    logic [soe_pkg::SAMPLE_W-1:0] store_rdata;

    assign sample_clamp = bin_value[soe_pkg::VALUE_W-1] ? '0
                        : soe_pkg::SAMPLE_W'(unsigned'(bin_value));
    assign in_range     = bin_count_reg < soe_pkg::CNT_W'(soe_pkg::NUM_BINS);
    assign p1_prod_next = soe_pkg::PROD_W'(sample_clamp)
                        * soe_pkg::PROD_W'(soe_pkg::DIV100_RECIP);

    assign rd_req.en  = accept && in_range;
    assign rd_req.idx = bin_count_reg[soe_pkg::IDX_W-1:0];

    always_comb
    begin
        bin_count_next = bin_count_reg;
        if (accept)
        begin
            if (last_bin)
            begin
                bin_count_next = '0;
            end
            else if (in_range)
            begin
                bin_count_next = bin_count_reg + soe_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= '0;
        end
        else
        begin
            bin_count_reg <= bin_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_sample_reg   <= sample_clamp;
            p1_prod_reg     <= p1_prod_next;
            p1_last_reg     <= last_bin;
            p1_time_reg     <= timestamp;
            p1_idx_reg      <= rd_req.idx;
            p1_in_range_reg <= in_range;
        end
    end

    soe_frame_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd_req),
        .wr      (wr_req),
        .rd_data (store_rdata)
    );

    // stage 2: emphasis, store write-back, energy accumulation
    logic [soe_pkg::SAMPLE_W-1:0] s2_sample;
    logic [soe_pkg::SAMPLE_W-1:0] s2_prev;
    logic [soe_pkg::VALUE_W-1:0]  s2_emph;
    logic [soe_pkg::ENERGY_W-1:0] cur_energy_reg, cur_energy_next;
    logic [soe_pkg::ENERGY_W-1:0] prev_energy_reg, prev_energy_next;
    logic                         s2_move;
    logic [soe_pkg::VALUE_W-1:0]  p2_emph_reg;
    logic                         p2_last_reg;
    logic [soe_pkg::TIME_W-1:0]   p2_time_reg;
    logic [soe_pkg::ENERGY_W-1:0] p2_cur_energy_reg;
    logic [soe_pkg::ENERGY_W-1:0] p2_prev_energy_reg;

    assign s2_move   = p1_valid_reg && en2;
    assign s2_sample = p1_last_reg
                     ? soe_pkg::SAMPLE_W'(p1_prod_reg >> soe_pkg::DIV100_SHIFT)
                     : p1_sample_reg;
    assign s2_prev   = p1_in_range_reg ? store_rdata : '0;
    assign s2_emph   = soe_pkg::VALUE_W'(s2_sample)
                     + ((s2_sample > s2_prev)
                        ? soe_pkg::VALUE_W'(s2_sample - s2_prev) : '0);

    assign cur_energy_next  = soe_pkg::energy_sat_add(cur_energy_reg, s2_sample);
    assign prev_energy_next = soe_pkg::energy_sat_add(prev_energy_reg, s2_prev);

    assign wr_req.en   = s2_move && p1_in_range_reg;
    assign wr_req.idx  = p1_idx_reg;
    assign wr_req.data = s2_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_energy_reg  <= '0;
            prev_energy_reg <= '0;
        end
        else if (s2_move)
        begin
            cur_energy_reg  <= p1_last_reg ? '0 : cur_energy_next;
            prev_energy_reg <= p1_last_reg ? '0 : prev_energy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            p2_emph_reg        <= s2_emph;
            p2_last_reg        <= p1_last_reg;
            p2_time_reg        <= p1_time_reg;
            p2_cur_energy_reg  <= cur_energy_next;
            p2_prev_energy_reg <= prev_energy_next;
        end
    end

    // stage 3: required rise = previous energy * multiplier
    logic [soe_pkg::NEED_W-1:0]   p3_need_reg, p3_need_next;
    logic [soe_pkg::ENERGY_W-1:0] p3_diff_reg;
    logic                         p3_rising_reg;
    logic [soe_pkg::VALUE_W-1:0]  p3_emph_reg;
    logic                         p3_last_reg;
    logic [soe_pkg::TIME_W-1:0]   p3_time_reg;

    assign p3_need_next = soe_pkg::NEED_W'(p2_prev_energy_reg)
                        * soe_pkg::NEED_W'(energy_multiplier_reg);

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && en3)
        begin
            p3_need_reg   <= p3_need_next;
            p3_diff_reg   <= p2_cur_energy_reg - p2_prev_energy_reg;
            p3_rising_reg <= p2_cur_energy_reg > p2_prev_energy_reg;
            p3_emph_reg   <= p2_emph_reg;
            p3_last_reg   <= p2_last_reg;
            p3_time_reg   <= p2_time_reg;
        end
    end

    // stage 4: onset compare and hold-off against last change
    logic [soe_pkg::RISE_W-1:0] rise;
    logic [soe_pkg::TIME_W-1:0] last_change_time_reg;
    logic [soe_pkg::TIME_W-1:0] elapsed;
    logic                       onset;
    logic                       s4_move;
    logic [soe_pkg::VALUE_W-1:0] emph_reg;
    logic                       frame_end_reg;
    logic                       color_change_reg;

    assign s4_move = p3_valid_reg && en_out;
    assign rise    = {p3_diff_reg, 8'd0};
    assign elapsed = p3_time_reg - last_change_time_reg;
    assign onset   = p3_last_reg && p3_rising_reg
                  && (soe_pkg::NEED_W'(rise) > p3_need_reg)
                  && (elapsed > min_interval_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_change_time_reg <= '0;
        end
        else if (s4_move && onset)
        begin
            last_change_time_reg <= p3_time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_move)
        begin
            emph_reg         <= p3_emph_reg;
            frame_end_reg    <= p3_last_reg;
            color_change_reg <= onset;
        end
    end

    assign res_valid        = res_valid_reg;
    assign emphasized_value = emph_reg;
    assign frame_end        = frame_end_reg;
    assign color_change     = color_change_reg;

endmodule

### src/soe_checker.sv
// Port-level assertions for the spectral onset emphasis unit, bound to the top level.
module soe_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [soe_pkg::VALUE_W-1:0] emphasized_value,
    input logic                        frame_end,
    input logic                        color_change
);

    // color change is only decided at a frame boundary
    a_change_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_end |-> !color_change)
        else $error("color_change without frame_end");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(emphasized_value)
            && $stable(frame_end) && $stable(color_change))
        else $error("stalled result changed");

    // emphasis is at most twice the largest clamped sample
    a_emph_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> emphasized_value != {soe_pkg::VALUE_W{1'b1}})
        else $error("emphasized_value out of range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind spectral_onset_emphasis_unit soe_checker u_soe_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pready           (pready),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .emphasized_value (emphasized_value),
    .frame_end        (frame_end),
    .color_change     (color_change)
);

### test/soe_onset_checker.sv
// Checker for the spectral onset emphasis unit: bus monitors, emphasis/onset predictor, compare.
module soe_onset_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [soe_pkg::ADDR_W-1:0]          paddr,
    input  logic [soe_pkg::DATA_W-1:0]          pwdata,
    input  logic [soe_pkg::DATA_W-1:0]          prdata,
    input  logic                                pready,
    input  logic                                bin_valid,
    input  logic                                bin_ready,
    input  logic [soe_pkg::VALUE_W-1:0]         bin_value,
    input  logic                                last_bin,
    input  logic [soe_pkg::TIME_W-1:0]          timestamp,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  logic [soe_pkg::VALUE_W-1:0]         emphasized_value,
    input  logic                                frame_end,
    input  logic                                color_change,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  onsets
);

    localparam logic [soe_pkg::ADDR_W-1:0] MULT_ADDR =
        soe_pkg::ADDR_W'(4 * soe_pkg::REG_ENERGY_MULT);
    localparam logic [soe_pkg::ADDR_W-1:0] INTERVAL_ADDR =
        soe_pkg::ADDR_W'(4 * soe_pkg::REG_MIN_INTERVAL);

    typedef struct {
        logic [soe_pkg::VALUE_W-1:0] value;
        logic                        fin;
        logic                        change;
    } emph_result_t;

    emph_result_t        emph_results_q[$];

    // predictor state
    logic [soe_pkg::SAMPLE_W-1:0] stored_bins[soe_pkg::NUM_BINS];
    logic [soe_pkg::ENERGY_W-1:0] frame_energy;
    logic [soe_pkg::ENERGY_W-1:0] stored_energy;
    logic [soe_pkg::TIME_W-1:0]   change_stamp;
    int unsigned                  bin_pos;
    logic [soe_pkg::MULT_W-1:0]   mult_q;
    logic [soe_pkg::TIME_W-1:0]   interval_q;

    function automatic logic [soe_pkg::ENERGY_W-1:0] energy_acc(
        input logic [soe_pkg::ENERGY_W-1:0] acc,
        input logic [soe_pkg::SAMPLE_W-1:0] v
    );
        longint sum;
        sum = longint'(acc) + longint'(v);
        return (sum > longint'(soe_pkg::ENERGY_MAX)) ? soe_pkg::ENERGY_MAX
                                                     : sum[soe_pkg::ENERGY_W-1:0];
    endfunction

    task automatic emphasize_bin(input logic [soe_pkg::VALUE_W-1:0] raw, input logic fin,
                                 input logic [soe_pkg::TIME_W-1:0] now);
        logic [soe_pkg::SAMPLE_W-1:0] s;
        logic [soe_pkg::SAMPLE_W-1:0] old;
        longint                       rise;
        longint                       need;
        logic [soe_pkg::TIME_W-1:0]   elapsed;
        emph_result_t                 r;
        s = raw[soe_pkg::VALUE_W-1] ? '0 : raw[soe_pkg::SAMPLE_W-1:0];
        if (fin)
            s = s / soe_pkg::SAMPLE_W'(100);
        old = '0;
        // bins past the store depth read as zero and are dropped
        if (bin_pos < soe_pkg::NUM_BINS)
        begin
            old = stored_bins[bin_pos];
            stored_bins[bin_pos] = s;
            bin_pos++;
        end
        r.value  = {1'b0, s} + ((s > old) ? {1'b0, s - old} : '0);
        r.fin    = fin;
        r.change = 1'b0;
        frame_energy  = energy_acc(frame_energy, s);
        stored_energy = energy_acc(stored_energy, old);
        if (fin)
        begin
            rise    = (longint'(frame_energy) - longint'(stored_energy)) * 256;
            need    = longint'(stored_energy) * longint'(mult_q);
            elapsed = now - change_stamp;
            if (rise > need && elapsed > interval_q)
            begin
                r.change     = 1'b1;
                change_stamp = now;
                onsets++;
            end
            frame_energy  = '0;
            stored_energy = '0;
            bin_pos       = 0;
        end
        emph_results_q = {emph_results_q, r};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("soe_onset_checker: %s mismatch at %0t: got %0h, expected %0h",
                 what, $realtime, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        emph_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < soe_pkg::NUM_BINS; i++)
                stored_bins[i] = '0;
            frame_energy  = '0;
            stored_energy = '0;
            change_stamp  = '0;
            bin_pos       = 0;
            mult_q        = soe_pkg::MULT_RESET;
            interval_q    = soe_pkg::INTERVAL_RESET;
            emph_results_q.delete();
            pending    = 0;
            mismatches = 0;
            onsets     = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == MULT_ADDR)
                        mult_q = pwdata[soe_pkg::MULT_W-1:0];
                    else if (paddr == INTERVAL_ADDR)
                        interval_q = pwdata;
                end
                else if (paddr == MULT_ADDR)
                begin
                    if (prdata !== soe_pkg::DATA_W'(mult_q))
                        report_mismatch("energy_multiplier readback", prdata,
                                        32'(mult_q));
                end
                else if (paddr == INTERVAL_ADDR)
                begin
                    if (prdata !== interval_q)
                        report_mismatch("min_interval readback", prdata, interval_q);
                end
            end
            if (bin_valid && bin_ready)
                emphasize_bin(bin_value, last_bin, timestamp);
            if (res_valid && res_ready)
            begin
                if (emph_results_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(emphasized_value), 32'h0);
                end
                else
                begin
                    want = emph_results_q.pop_front();
                    if (emphasized_value !== want.value)
                        report_mismatch("emphasized_value", 32'(emphasized_value),
                                        32'(want.value));
                    if (frame_end !== want.fin)
                        report_mismatch("frame_end", 32'(frame_end), 32'(want.fin));
                    if (color_change !== want.change)
                        report_mismatch("color_change", 32'(color_change),
                                        32'(want.change));
                end
            end
            pending = emph_results_q.size();
        end
    end

endmodule

### test/tb_spectral_onset_emphasis_unit.sv
// Top of the spectral onset emphasis unit testbench: clock, reset, stimulus and verdict.
module tb_spectral_onset_emphasis_unit;

    localparam int LATENCY     = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 300000;
    localparam logic [soe_pkg::ADDR_W-1:0] MULT_ADDR =
        soe_pkg::ADDR_W'(4 * soe_pkg::REG_ENERGY_MULT);
    localparam logic [soe_pkg::ADDR_W-1:0] INTERVAL_ADDR =
        soe_pkg::ADDR_W'(4 * soe_pkg::REG_MIN_INTERVAL);

    typedef enum int {MOOD_QUIET, MOOD_LOUD, MOOD_MIXED, MOOD_EDGES} frame_mood_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [soe_pkg::ADDR_W-1:0]    paddr;
    logic [soe_pkg::DATA_W-1:0]    pwdata;
    logic [soe_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          bin_valid;
    logic                          bin_ready;
    logic [soe_pkg::VALUE_W-1:0]   bin_value;
    logic                          last_bin;
    logic [soe_pkg::TIME_W-1:0]    timestamp;
    logic                          res_valid;
    logic                          res_ready = 1'b0;
    logic [soe_pkg::VALUE_W-1:0]   emphasized_value;
    logic                          frame_end;
    logic                          color_change;

    int                   mismatches;
    int                   pending;
    int                   onsets;

    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   holds_asked = 0;
    int                   holds_done  = 0;
    int                   hold_left   = 0;
    int                   cycle_count = 0;
    int                   bins_sent   = 0;
    int                   frames_sent = 0;
    int                   long_frames = 0;
    logic [soe_pkg::TIME_W-1:0] tick = '0;

    spectral_onset_emphasis_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .bin_valid        (bin_valid),
        .bin_ready        (bin_ready),
        .bin_value        (bin_value),
        .last_bin         (last_bin),
        .timestamp        (timestamp),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .emphasized_value (emphasized_value),
        .frame_end        (frame_end),
        .color_change     (color_change)
    );

    soe_onset_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .bin_valid        (bin_valid),
        .bin_ready        (bin_ready),
        .bin_value        (bin_value),
        .last_bin         (last_bin),
        .timestamp        (timestamp),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .emphasized_value (emphasized_value),
        .frame_end        (frame_end),
        .color_change     (color_change),
        .mismatches       (mismatches),
        .pending          (pending),
        .onsets           (onsets)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("tb_spectral_onset_emphasis_unit: errors");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (holds_done != holds_asked)
        begin
            holds_done <= holds_asked;
            hold_left  <= HOLD_CYCLES;
            res_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic push_bin(input logic [soe_pkg::VALUE_W-1:0] v, input logic fin,
                            input logic [soe_pkg::TIME_W-1:0] ts);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            bin_valid <= 1'b0;
            @(negedge clk);
        end
        bin_valid <= 1'b1;
        bin_value <= v;
        last_bin  <= fin;
        timestamp <= ts;
        do
            @(posedge clk);
        while (!bin_ready);
        @(negedge clk);
        bins_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [soe_pkg::ADDR_W-1:0] a,
                              input logic [soe_pkg::DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // write both registers and read them back; the checker compares the reads
    task automatic set_registers(input logic [soe_pkg::DATA_W-1:0] mult_word,
                                 input logic [soe_pkg::DATA_W-1:0] interval);
        apb_access(1'b1, MULT_ADDR, mult_word);
        apb_access(1'b1, INTERVAL_ADDR, interval);
        apb_access(1'b0, MULT_ADDR, '0);
        apb_access(1'b0, INTERVAL_ADDR, '0);
    endtask

    task automatic drain;
        bin_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    function automatic logic [soe_pkg::VALUE_W-1:0] pick_bin(input frame_mood_t mood);
        case (mood)
            MOOD_QUIET: return soe_pkg::VALUE_W'($urandom_range(0, 255));
            MOOD_LOUD:  return soe_pkg::VALUE_W'($urandom_range(32'h400000, 32'h7FFFFF));
            MOOD_MIXED: return soe_pkg::VALUE_W'($urandom);
            default:
                case ($urandom_range(0, 4))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return 24'hFFFFFF;
                    3:       return 24'h000001;
                    default: return 24'h000000;
                endcase
        endcase
    endfunction

    task automatic run_frames(input int target);
        int          sent;
        int          len;
        int          roll;
        frame_mood_t mood;
        logic [31:0] step;
        sent = 0;
        while (sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                len = $urandom_range(1, 8);
            else if (roll < 93)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(60, 70);
            if (len > soe_pkg::NUM_BINS)
                long_frames++;
            mood = frame_mood_t'($urandom_range(0, 3));
            for (int k = 0; k < len - 1; k++)
                push_bin(pick_bin(mood), 1'b0, $urandom);
            roll = $urandom_range(0, 99);
            if (roll < 30)
                step = $urandom_range(0, 2000);
            else if (roll < 70)
                step = $urandom_range(0, 300000);
            else
                step = $urandom;
            tick += step;
            push_bin(pick_bin(mood), 1'b1, tick);
            sent += len;
            frames_sent++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        bin_valid = 1'b0;
        bin_value = '0;
        last_bin  = 1'b0;
        timestamp = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 35;
        rx_idle_pct = 78;

        // reset settings: onset past the hold-off, then no rise, then equal energies
        push_bin(24'h7FFFFF, 1'b0, 32'h0);
        push_bin(24'h800000, 1'b0, 32'h0);
        push_bin(24'h7FFFFF, 1'b1, 32'd100001);
        push_bin(24'h000001, 1'b0, 32'h0);
        push_bin(24'hFFFFFF, 1'b0, 32'h0);
        push_bin(24'h000064, 1'b1, 32'd200001);
        push_bin(24'h000064, 1'b1, 32'hFFFFFFF0);
        drain();

        // zero multiplier, upper write bits set; elapsed equal to, above, and wrapped
        set_registers(32'hFFFFF000, 32'd50);
        push_bin(24'h400000, 1'b0, 32'h0);
        push_bin(24'h7FFFFF, 1'b1, 32'd100051);
        push_bin(24'h7FFFFF, 1'b0, 32'h0);
        push_bin(24'h7FFFFF, 1'b1, 32'd100052);
        push_bin(24'h7FFFFF, 1'b0, 32'h0);
        push_bin(24'h7FFFFF, 1'b0, 32'h0);
        push_bin(24'h7FFFFF, 1'b1, 32'd50);
        frames_sent += 6;
        drain();

        tick = 32'd50;
        set_registers(32'h0, 32'h0);
        run_frames(90);
        drain();

        tx_idle_pct = 78;
        rx_idle_pct = 35;
        set_registers(32'd4095, 32'd1000);
        run_frames(90);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_registers(soe_pkg::DATA_W'($urandom_range(0, 4095)), 32'hFFFFFFFF);
        holds_asked++;
        run_frames(90);
        drain();

        // reset values written back; a full-scale frame past the store depth saturates
        set_registers(32'd256, 32'd100000);
        for (int k = 0; k < soe_pkg::NUM_BINS + 1; k++)
            push_bin(24'h7FFFFF, 1'b0, $urandom);
        tick += 32'd200000;
        push_bin(24'h7FFFFF, 1'b1, tick);
        frames_sent++;
        long_frames++;
        run_frames(90);
        drain();

        repeat (4 * LATENCY) @(negedge clk);
        $display("Run covered %0d bins in %0d frames across six register settings,",
                 bins_sent, frames_sent);
        $display("%0d frames past the store depth, %0d color changes, and a %0d-cycle hold-off.",
                 long_frames, onsets, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("tb_spectral_onset_emphasis_unit: clean");
        else
            $display("tb_spectral_onset_emphasis_unit: errors");
        $finish;
    end

endmodule

### sim.f
src/soe_pkg.sv
src/soe_frame_store.sv
src/spectral_onset_emphasis_unit.sv
src/soe_checker.sv
test/soe_onset_checker.sv
test/tb_spectral_onset_emphasis_unit.sv
